// ----- src/overwriting_byte_ring_buffer_core_defines.svh -----
// assertion macros for the overwriting byte ring buffer
`ifndef OVERWRITING_BYTE_RING_BUFFER_CORE_DEFINES_SVH
`define OVERWRITING_BYTE_RING_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OBRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obrb check failed");

// next-cycle implication, checked outside reset
`define OBRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obrb check failed");

`endif

// ----- src/obrb_pkg.sv -----
// shared types and constants of the overwriting byte ring buffer
`default_nettype none

package obrb_pkg;

    localparam int DATA_W = 8;
    localparam int CAP_W  = 9;
    localparam int OP_W   = 2;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_GET   = 2'd1;
    localparam t_op OP_PEEK  = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    // status of one word, from the pointer logic to the output side
    typedef struct packed {
        logic             rd_en;
        logic             success;
        logic             is_full;
        logic             is_empty;
        logic [CAP_W-1:0] fill_count;
    } t_status;

endpackage

`default_nettype wire

// ----- src/obrb_if.sv -----
// handshake channels of the overwriting byte ring buffer
`default_nettype none

interface obrb_in_if;
    logic                           valid;
    logic                           ready;
    logic [obrb_pkg::OP_W-1:0]      operation;
    logic [obrb_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output operation, output write_data, input ready);
    modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface obrb_out_if;
    logic                           valid;
    logic                           ready;
    logic [obrb_pkg::DATA_W-1:0]    read_data;
    logic                           success;
    logic                           is_full;
    logic                           is_empty;
    logic [obrb_pkg::CAP_W-1:0]     fill_count;

    modport source (output valid, output read_data, output success, output is_full,
                    output is_empty, output fill_count, input ready);
    modport sink   (input valid, input read_data, input success, input is_full,
                    input is_empty, input fill_count, output ready);
endinterface

`default_nettype wire

// ----- src/overwriting_byte_ring_buffer_core.sv -----
// top level of the overwriting byte ring buffer
`default_nettype none
`include "overwriting_byte_ring_buffer_core_defines.svh"

// Byte ring buffer that overwrites its oldest byte when full. Words carry one of
// put, get, peek-read or clear; each gives exactly one result word with the read
// byte, a success bit, the full and empty flags and the fill count. One word is
// taken per clock unless the output side stalls, set by the single-port byte
// memory that is either written (put) or read (get, peek) in the cycle of
// acceptance. A result passes the pending stage, where the memory read data is
// registered, and then the output register. The byte store has no reset and
// no clearing pass; pointers, flags and the capacity reset at once. Writing the
// capacity (0 is taken as 1, values above DEPTH as DEPTH) also clears all
// pointers; the user must write it only while no word is in flight (unchecked).
module overwriting_byte_ring_buffer_core #(
    parameter int DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [obrb_pkg::CAP_W-1:0]    i_cfg_wdata,
    obrb_in_if.sink                            i_in_ch,
    obrb_out_if.source                         o_out_ch
);

    localparam int AW = $clog2(DEPTH);

    logic [obrb_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [obrb_pkg::DATA_W-1:0] r_mem_q;

    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;
    obrb_pkg::t_status   status;

    logic                r_p_valid;
    obrb_pkg::t_status   r_p_stat;
    logic                r_o_valid;
    logic [obrb_pkg::DATA_W-1:0] r_o_data;
    obrb_pkg::t_status   r_o_stat;

    logic                adv;
    logic                acc;

    // handshake
    assign adv             = r_p_valid && (!r_o_valid || o_out_ch.ready);
    assign i_in_ch.ready   = !r_p_valid || adv;
    assign acc             = i_in_ch.valid && i_in_ch.ready;

    obrb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_operation (i_in_ch.operation),
        .o_mem_addr  (mem_addr),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_status    (status)
    );

    // byte store, one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_in_ch.write_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_addr];
        end
    end

    // pending stage waiting for read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (acc) begin
            r_p_valid <= 1'b1;
        end else if (adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_stat <= status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_stat <= r_p_stat;
            r_o_data <= r_p_stat.rd_en ? r_mem_q : '0;
        end
    end

    assign o_out_ch.valid      = r_o_valid;
    assign o_out_ch.read_data  = r_o_data;
    assign o_out_ch.success    = r_o_stat.success;
    assign o_out_ch.is_full    = r_o_stat.is_full;
    assign o_out_ch.is_empty   = r_o_stat.is_empty;
    assign o_out_ch.fill_count = r_o_stat.fill_count;

    // checks
    `OBRB_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, r_o_valid,
        (r_o_stat.fill_count == '0) == r_o_stat.is_empty)
    `OBRB_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_o_valid && !r_o_stat.success,
        r_o_data == '0)
    `OBRB_ASSERT_NOW(a_flags_apart, i_clk, i_rst_n, r_o_valid,
        !(r_o_stat.is_full && r_o_stat.is_empty))
    `OBRB_ASSERT_NEXT(a_pending_moves, i_clk, i_rst_n, r_p_valid && !r_o_valid,
        r_o_valid)

endmodule

`default_nettype wire

// ----- src/obrb_ctrl.sv -----
// pointer state, operation decode and memory access control
`default_nettype none

module obrb_ctrl #(
    parameter int DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [obrb_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_acc,
    input  wire logic [obrb_pkg::OP_W-1:0]     i_operation,
    output logic [$clog2(DEPTH)-1:0]           o_mem_addr,
    output logic                               o_mem_we,
    output logic                               o_mem_re,
    output obrb_pkg::t_status                  o_status
);

    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = ((AW > obrb_pkg::CAP_W) ? AW : obrb_pkg::CAP_W) + 1;
    localparam int CAP_RST = (DEPTH < 256) ? DEPTH : 256;

    logic [AW-1:0] r_w, r_o, r_p;
    logic [AW-1:0] n_w, n_o, n_p;
    logic          r_full, n_full;
    logic [XW-1:0] r_ucap, n_ucap;

    logic          empty;
    logic [AW-1:0] o_adv;
    logic [XW-1:0] cnt;
    logic          st_rd_en;
    logic          st_success;

    // next slot with wrap at the capacity in use
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p,
                                             input logic [XW-1:0] cap);
        logic [XW-1:0] s;
        s = XW'(p) + XW'(1);
        return (s >= cap) ? '0 : AW'(s);
    endfunction

    assign empty = !r_full && (r_w == r_o);
    assign o_adv = f_next(r_o, r_ucap);

    // capacity clamp
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_ucap = XW'(1);
        end else if (XW'(i_cfg_wdata) > XW'(DEPTH)) begin
            n_ucap = XW'(DEPTH);
        end else begin
            n_ucap = XW'(i_cfg_wdata);
        end
    end

    // operation decode and next pointers
    always_comb begin
        n_w        = r_w;
        n_o        = r_o;
        n_p        = r_p;
        n_full     = r_full;
        o_mem_addr = r_w;
        o_mem_we   = 1'b0;
        o_mem_re   = 1'b0;
        st_rd_en   = 1'b0;
        st_success = 1'b1;
        if (i_acc) begin
            unique case (i_operation)
                obrb_pkg::OP_PUT: begin
                    o_mem_we = 1'b1;
                    if (r_full) begin
                        if (r_p == r_o) begin
                            n_p = o_adv;
                        end
                        n_o = o_adv;
                    end
                    n_w    = f_next(r_w, r_ucap);
                    n_full = (n_w == n_o);
                end
                obrb_pkg::OP_GET: begin
                    if (empty) begin
                        st_success = 1'b0;
                    end else begin
                        o_mem_re   = 1'b1;
                        o_mem_addr = r_o;
                        st_rd_en   = 1'b1;
                        n_full     = 1'b0;
                        if (r_p == r_o) begin
                            n_p = o_adv;
                        end
                        n_o = o_adv;
                    end
                end
                obrb_pkg::OP_PEEK: begin
                    if (empty) begin
                        st_success = 1'b0;
                    end else begin
                        o_mem_re   = 1'b1;
                        o_mem_addr = r_p;
                        st_rd_en   = 1'b1;
                        n_p        = f_next(r_p, r_ucap);
                    end
                end
                obrb_pkg::OP_CLEAR: begin
                    n_w    = '0;
                    n_o    = '0;
                    n_p    = '0;
                    n_full = 1'b0;
                end
                default: begin
                    n_full = r_full;
                end
            endcase
        end
    end

    // flags and count after the operation
    always_comb begin
        if (n_full) begin
            cnt = r_ucap;
        end else if (n_w >= n_o) begin
            cnt = XW'(n_w) - XW'(n_o);
        end else begin
            cnt = r_ucap + XW'(n_w) - XW'(n_o);
        end
        o_status.rd_en      = st_rd_en;
        o_status.success    = st_success;
        o_status.is_full    = n_full;
        o_status.is_empty   = !n_full && (n_w == n_o);
        o_status.fill_count = cnt[obrb_pkg::CAP_W-1:0];
    end

    // pointer registers; a capacity write restarts the buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_o    <= '0;
            r_p    <= '0;
            r_full <= 1'b0;
            r_ucap <= XW'(CAP_RST);
        end else if (i_cfg_we) begin
            r_w    <= '0;
            r_o    <= '0;
            r_p    <= '0;
            r_full <= 1'b0;
            r_ucap <= n_ucap;
        end else begin
            r_w    <= n_w;
            r_o    <= n_o;
            r_p    <= n_p;
            r_full <= n_full;
        end
    end

endmodule

`default_nettype wire
